FILE: src/dfe_pkg.sv
// ----------------------------------------------------------------------------
// dfe_pkg
// Shared types and constants of the delimited frame extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package dfe_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 9;

    localparam logic [BYTE_W-1:0] DELIM_FIRST_RST  = 8'd42;
    localparam logic [BYTE_W-1:0] DELIM_SECOND_RST = 8'd38;
    localparam logic [BYTE_W-1:0] DELIM_THIRD_RST  = 8'd42;

    localparam logic [1:0] REG_DELIM_FIRST  = 2'd0;
    localparam logic [1:0] REG_DELIM_SECOND = 2'd1;
    localparam logic [1:0] REG_DELIM_THIRD  = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] first;
        logic [BYTE_W-1:0] second;
        logic [BYTE_W-1:0] third;
    } delim_t;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              frame_end;
        logic [LEN_W-1:0]  frame_length;
        logic              overflow;
    } result_t;

endpackage

`default_nettype wire

FILE: src/dfe_front.sv
// ----------------------------------------------------------------------------
// dfe_front
// Delimiter hunt, held byte and look-ahead window; classifies each byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dfe_front
    import dfe_pkg::*;
#(
    parameter int MAX_PAYLOAD = 256
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire delim_t            delim,
    input  wire logic              accept,
    input  wire logic [BYTE_W-1:0] rx_byte,
    output logic                   push,
    output result_t                result
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam int EXT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    logic              in_frame_reg, in_frame_next;
    logic [1:0]        fill_reg, fill_next;
    logic              held_valid_reg, held_valid_next;
    logic [BYTE_W-1:0] held_reg, held_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0] win_reg [3];
    logic [BYTE_W-1:0] win_next [3];

    logic [BYTE_W-1:0] nw [3];
    logic [1:0]        f;
    logic [1:0]        nf;
    logic              match;
    logic [CNT_W-1:0]  len;
    logic [EXT_W-1:0]  len_ext;

    always_comb
    begin
        in_frame_next   = in_frame_reg;
        fill_next       = fill_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        count_next      = count_reg;
        win_next        = win_reg;
        push            = 1'b0;
        result          = '0;
        nw              = win_reg;
        f               = 2'd0;
        nf              = 2'd0;
        match           = 1'b0;
        len             = CNT_W'(count_reg + 1'b1);
        len_ext         = EXT_W'(len);

        if (accept)
        begin
            if (!in_frame_reg)
            begin
                if (fill_reg != 2'd3)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (fill_reg == 2'(i))
                        begin
                            nw[i] = rx_byte;
                        end
                    end
                    nf = fill_reg + 2'd1;
                end
                else
                begin
                    nw[0] = win_reg[1];
                    nw[1] = win_reg[2];
                    nw[2] = rx_byte;
                    nf    = 2'd3;
                end
                win_next = nw;
                match = (nf == 2'd3) && (nw[0] == delim.first) &&
                        (nw[1] == delim.second) && (nw[2] == delim.third);
                if (match)
                begin
                    in_frame_next   = 1'b1;
                    fill_next       = 2'd0;
                    held_valid_next = 1'b0;
                    held_next       = '0;
                    count_next      = '0;
                end
                else
                begin
                    fill_next = nf;
                end
            end
            else if (!held_valid_reg)
            begin
                held_next       = rx_byte;
                held_valid_next = 1'b1;
            end
            else
            begin
                f = (fill_reg > 2'd2) ? 2'd2 : fill_reg;
                for (int i = 0; i < 3; i++)
                begin
                    if (f == 2'(i))
                    begin
                        nw[i] = rx_byte;
                    end
                end
                nf = f + 2'd1;
                if (nf != 2'd3)
                begin
                    win_next  = nw;
                    fill_next = nf;
                end
                else
                begin
                    match = (nw[0] == delim.first) && (nw[1] == delim.second) &&
                            (nw[2] == delim.third);
                    push  = 1'b1;
                    result.payload_byte = held_reg;
                    if (match || (len >= CNT_W'(MAX_PAYLOAD)))
                    begin
                        result.frame_end    = 1'b1;
                        result.frame_length = len_ext[LEN_W-1:0];
                        result.overflow     = !match;
                        win_next            = nw;
                        in_frame_next       = 1'b0;
                        fill_next           = 2'd0;
                        held_valid_next     = 1'b0;
                        held_next           = '0;
                        count_next          = '0;
                    end
                    else
                    begin
                        count_next  = len;
                        held_next   = nw[0];
                        win_next[0] = nw[1];
                        win_next[1] = nw[2];
                        win_next[2] = nw[2];
                        fill_next   = 2'd2;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            fill_reg       <= 2'd0;
            held_valid_reg <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            in_frame_reg   <= in_frame_next;
            fill_reg       <= fill_next;
            held_valid_reg <= held_valid_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
        win_reg  <= win_next;
    end

endmodule

`default_nettype wire

FILE: src/dfe_queue.sv
// ----------------------------------------------------------------------------
// dfe_queue
// Two-entry result queue between the classifier and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dfe_queue
    import dfe_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         full,
    input  wire logic    pop,
    output logic         not_empty,
    output result_t      head
);

    result_t    mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: src/dfe_back.sv
// ----------------------------------------------------------------------------
// dfe_back
// Output register; drains the queue and drives the master stream.
// ----------------------------------------------------------------------------
`default_nettype none

module dfe_back
    import dfe_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    q_valid,
    input  wire result_t q_head,
    output logic         q_pop,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    output logic [23:0]  m_tdata,
    output logic         m_tlast,
    output logic [0:0]   m_tuser
);

    logic    valid_reg, valid_next;
    result_t data_reg, data_next;

    assign q_pop = q_valid && (!valid_reg || m_tready);

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (q_pop)
        begin
            valid_next = 1'b1;
            data_next  = q_head;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0, data_reg.frame_length, data_reg.payload_byte};
    assign m_tlast  = data_reg.frame_end;
    assign m_tuser  = data_reg.overflow;

endmodule

`default_nettype wire

FILE: src/delimited_frame_extractor_core.sv
// ----------------------------------------------------------------------------
// delimited_frame_extractor_core
// Takes one received byte per transfer and extracts the payload between a
// three-byte opening delimiter and the closing delimiter. A new byte is
// accepted every cycle while the result queue is not full. A payload byte
// is released once the three bytes after it have arrived, then passes
// through two register stages (result queue and output register). The
// last payload byte carries tlast and the frame length; a frame cut at
// MAX_PAYLOAD bytes also carries the overflow flag in tuser. The delimiter
// bytes are set through the APB registers at 0x0, 0x4 and 0x8.
// ----------------------------------------------------------------------------
`default_nettype none

module delimited_frame_extractor_core
    import dfe_pkg::*;
#(
    parameter int MAX_PAYLOAD = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // [7:0] payload_byte, [16:8] frame_length
    output logic             m_tlast,
    output logic      [0:0]  m_tuser    // [0] overflow
);

    delim_t  delim_reg, delim_next;
    logic    cfg_wr;
    logic    accept;
    logic    push;
    result_t result;
    logic    q_full, q_valid, q_pop;
    result_t q_head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        delim_next = delim_reg;
        if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_DELIM_FIRST:  delim_next.first  = pwdata[7:0];
                REG_DELIM_SECOND: delim_next.second = pwdata[7:0];
                REG_DELIM_THIRD:  delim_next.third  = pwdata[7:0];
                default:          delim_next = delim_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_DELIM_FIRST:  prdata = {24'd0, delim_reg.first};
            REG_DELIM_SECOND: prdata = {24'd0, delim_reg.second};
            REG_DELIM_THIRD:  prdata = {24'd0, delim_reg.third};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg.first  <= DELIM_FIRST_RST;
            delim_reg.second <= DELIM_SECOND_RST;
            delim_reg.third  <= DELIM_THIRD_RST;
        end
        else
        begin
            delim_reg <= delim_next;
        end
    end

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    dfe_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .delim   (delim_reg),
        .accept  (accept),
        .rx_byte (s_tdata),
        .push    (push),
        .result  (result)
    );

    dfe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (result),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    dfe_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
